// File: rtl/core/mwf_pkg.sv
// Maze walker package: grid geometry, operation/status/heading codes,
// result struct, move order table and cell address helper.
// No dependencies.
package mwf_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;
  localparam int ROW_W     = (GRID_ROWS > 2) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W     = (GRID_COLS > 2) ? $clog2(GRID_COLS) : 1;
  localparam int DEPTH     = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CELL_W    = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MOVED    = 3'd1,
    ST_EXIT     = 3'd2,
    ST_NO_ENTRY = 3'd3,
    ST_BLOCKED  = 3'd4,
    ST_NOT_WALK = 3'd5
  } stat_t;

  typedef enum logic [1:0] {
    HEAD_N = 2'd0,
    HEAD_S = 2'd1,
    HEAD_E = 2'd2,
    HEAD_W = 2'd3
  } head_t;

  typedef struct packed {
    stat_t       status;
    logic [4:0]  row;
    logic [4:0]  col;
    head_t       heading;
  } res_t;

  // right, ahead, left, back
  function automatic head_t move_dir(input head_t h, input logic [1:0] k);
    head_t d;
    d = HEAD_N;
    case (h)
      HEAD_N: begin
        case (k)
          2'd0:    d = HEAD_E;
          2'd1:    d = HEAD_N;
          2'd2:    d = HEAD_W;
          default: d = HEAD_S;
        endcase
      end
      HEAD_S: begin
        case (k)
          2'd0:    d = HEAD_W;
          2'd1:    d = HEAD_S;
          2'd2:    d = HEAD_E;
          default: d = HEAD_N;
        endcase
      end
      HEAD_E: begin
        case (k)
          2'd0:    d = HEAD_S;
          2'd1:    d = HEAD_E;
          2'd2:    d = HEAD_N;
          default: d = HEAD_W;
        endcase
      end
      default: begin
        case (k)
          2'd0:    d = HEAD_N;
          2'd1:    d = HEAD_W;
          2'd2:    d = HEAD_S;
          default: d = HEAD_E;
        endcase
      end
    endcase
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return ADDR_W'(32'(r) * GRID_COLS + 32'(c));
  endfunction

endpackage

// File: rtl/core/mwf_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module mwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/core/mwf_ctrl.sv
// Maze walker sequencer: decodes items, drives the grid RAM port,
// scans row 0 for the entrance and probes neighbors for a step.
// Depends on mwf_pkg.
module mwf_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mwf_pkg::op_t               in_op,
  input  logic [4:0]                 in_row,
  input  logic [4:0]                 in_col,
  input  logic [7:0]                 in_value,
  input  logic [7:0]                 open_mark,
  output logic                       mem_we,
  output logic                       mem_re,
  output logic [mwf_pkg::ADDR_W-1:0] mem_addr,
  output logic [7:0]                 mem_wdata,
  input  logic [7:0]                 mem_rdata,
  output logic                       res_valid,
  input  logic                       res_take,
  output mwf_pkg::res_t              res
);
  import mwf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STEP,
    S_DONE
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] pos_row;
  logic [COL_W-1:0] pos_col;
  head_t            heading;
  logic             walking;
  stat_t            status;
  logic [COL_W:0]   scan_cnt;
  logic [2:0]       k;
  logic             pend;
  logic             pend_inb;
  head_t            pend_dir;
  logic [ROW_W-1:0] pend_row;
  logic [COL_W-1:0] pend_col;

  logic             accept;
  logic             load_ok;
  logic             hit;
  head_t            cur_dir;
  logic             nb_inb;
  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_ok   = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
  assign hit       = pend && pend_inb && (mem_rdata == open_mark);
  assign cur_dir   = move_dir(heading, k[1:0]);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status  = status;
    res.row     = 5'(pos_row);
    res.col     = 5'(pos_col);
    res.heading = heading;
  end

  always_comb begin
    nb_row = pos_row;
    nb_col = pos_col;
    nb_inb = 1'b1;
    case (cur_dir)
      HEAD_N: begin
        nb_inb = (pos_row != '0);
        nb_row = pos_row - ROW_W'(1);
      end
      HEAD_S: begin
        nb_inb = (pos_row != ROW_W'(GRID_ROWS - 1));
        nb_row = pos_row + ROW_W'(1);
      end
      HEAD_E: begin
        nb_inb = (pos_col != COL_W'(GRID_COLS - 1));
        nb_col = pos_col + COL_W'(1);
      end
      default: begin
        nb_inb = (pos_col != '0);
        nb_col = pos_col - COL_W'(1);
      end
    endcase
  end

  // accesses never overlap: one item at a time, one port use per cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = in_value;
    case (state)
      S_IDLE: begin
        if (accept && in_op == OP_LOAD && load_ok) begin
          mem_we   = 1'b1;
          mem_addr = cell_addr(ROW_W'(in_row), COL_W'(in_col));
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_addr  = cell_addr('0, pend_col);
          mem_wdata = (open_mark == 8'd0) ? 8'hff : 8'h00;
        end else if (scan_cnt != (COL_W+1)'(GRID_COLS)) begin
          mem_re   = 1'b1;
          mem_addr = cell_addr('0, scan_cnt[COL_W-1:0]);
        end
      end
      S_STEP: begin
        if (!hit && k != 3'd4 && nb_inb) begin
          mem_re   = 1'b1;
          mem_addr = cell_addr(nb_row, nb_col);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos_row  <= '0;
      pos_col  <= '0;
      heading  <= HEAD_S;
      walking  <= 1'b0;
      status   <= ST_OK;
      pend     <= 1'b0;
      scan_cnt <= '0;
      k        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend <= 1'b0;
            case (in_op)
              OP_START: begin
                scan_cnt <= '0;
                state    <= S_SCAN;
              end
              OP_STEP: begin
                if (walking) begin
                  k     <= '0;
                  state <= S_STEP;
                end else begin
                  status <= ST_NOT_WALK;
                  state  <= S_DONE;
                end
              end
              default: begin
                status <= ST_OK;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            pos_row <= ROW_W'(1);
            pos_col <= pend_col;
            heading <= HEAD_S;
            if (GRID_ROWS == 2) begin
              status  <= ST_EXIT;
              walking <= 1'b0;
            end else begin
              status  <= ST_OK;
              walking <= 1'b1;
            end
            state <= S_DONE;
          end else if (scan_cnt == (COL_W+1)'(GRID_COLS)) begin
            status  <= ST_NO_ENTRY;
            walking <= 1'b0;
            state   <= S_DONE;
          end else begin
            pend     <= 1'b1;
            pend_inb <= 1'b1;
            pend_col <= scan_cnt[COL_W-1:0];
            scan_cnt <= scan_cnt + (COL_W+1)'(1);
          end
        end
        S_STEP: begin
          if (hit) begin
            pos_row <= pend_row;
            pos_col <= pend_col;
            heading <= pend_dir;
            if (pend_row == ROW_W'(GRID_ROWS - 1)) begin
              status  <= ST_EXIT;
              walking <= 1'b0;
            end else begin
              status <= ST_MOVED;
            end
            state <= S_DONE;
          end else if (k == 3'd4) begin
            status <= ST_BLOCKED;
            state  <= S_DONE;
          end else begin
            pend     <= 1'b1;
            pend_inb <= nb_inb;
            pend_dir <= cur_dir;
            pend_row <= nb_row;
            pend_col <= nb_col;
            k        <= k + 3'd1;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/maze_wall_follower.sv
// Maze walker top level: stream ports, open_mark register, result
// output register, grid RAM and sequencer.
// Depends on mwf_pkg, mwf_ram, mwf_ctrl.
//
// Usage: each input transfer carries one item, opcode in s_axis_tuser.
// Load writes one grid cell, start searches row 0 for the entrance and
// places the walker one row below heading south, step moves the walker
// by the right-hand rule. Every item gives exactly one output transfer
// with the status in m_axis_tuser and the walker state in m_axis_tdata.
// cfg_data sets open_mark; write it only while the block is idle.
// One item is in work at a time. Load, no-op and step while not walking
// go straight to the result; a step while walking probes neighbors in turn
// (one RAM read per in-bounds probed neighbor, four at most, single-port grid RAM);
// start scans row 0 (one row-0 column read per cycle).
// The result sits in an output register, so the next item is accepted
// while it waits; a stalled receiver then holds the block after that
// item completes. Reset clears the walker to row 0, column 0, heading
// south, not walking, and open_mark to 1; the grid content is unknown
// until loaded.
module maze_wall_follower (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // cell_row[4:0], cell_col[9:5], cell_value[17:10]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // walker_row[4:0], walker_col[9:5], walker_heading[11:10]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import mwf_pkg::*;

  logic [7:0]        open_mark;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic              res_valid;
  logic              res_take;
  res_t              res;
  res_t              out_res;
  logic              out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_mark <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      open_mark <= cfg_data;
    end
  end

  mwf_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  mwf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (op_t'(s_axis_tuser)),
    .in_row    (s_axis_tdata[4:0]),
    .in_col    (s_axis_tdata[9:5]),
    .in_value  (s_axis_tdata[17:10]),
    .open_mark (open_mark),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_res.heading, out_res.col, out_res.row};
  assign m_axis_tuser  = out_res.status;

endmodule
